[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif

`endif

[hw/rtl/ivm_pkg.sv]
// Shared types, widths, register codes and sensitivity tables for the
// IMU vector magnitude pipeline. No dependencies.
package ivm_pkg;

    localparam int RAW_W = 16;
    localparam int SQ_W  = 32;
    localparam int DIV_W = 18;
    localparam int MAG_W = 28;
    localparam int RNG_W = 2;

    localparam logic CFG_GYRO  = 1'b0;
    localparam logic CFG_ACCEL = 1'b1;

    localparam logic REQ_ACCEL = 1'b0;
    localparam logic REQ_GYRO  = 1'b1;

    // counts per unit, in tenths
    localparam logic [DIV_W-1:0] GYRO_TENTHS [4] = '{
        18'd1310, 18'd655, 18'd328, 18'd164
    };
    localparam logic [DIV_W-1:0] ACCEL_TENTHS [4] = '{
        18'd163840, 18'd81920, 18'd40960, 18'd20480
    };

    typedef struct packed {
        logic             vld;
        logic [DIV_W-1:0] div;
    } t_tag;

    function automatic logic [DIV_W-1:0] divisor_tenths(
        input logic             req_type,
        input logic [RNG_W-1:0] gyro_range,
        input logic [RNG_W-1:0] accel_range
    );
        logic [DIV_W-1:0] d;
        if (req_type == REQ_GYRO) begin
            d = GYRO_TENTHS[gyro_range];
        end else begin
            d = ACCEL_TENTHS[accel_range];
        end
        return d;
    endfunction

endpackage

[hw/rtl/ivm_sqsum.sv]
// Two-stage sum of squares of three signed axis counts.
// Depends on ivm_pkg.
module ivm_sqsum (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  ivm_pkg::t_tag                      i_tag,
    input  logic signed [ivm_pkg::RAW_W-1:0]   i_raw_x,
    input  logic signed [ivm_pkg::RAW_W-1:0]   i_raw_y,
    input  logic signed [ivm_pkg::RAW_W-1:0]   i_raw_z,
    output ivm_pkg::t_tag                      o_tag,
    output logic        [ivm_pkg::SQ_W-1:0]    o_sum
);
    import ivm_pkg::*;

    logic signed [2*RAW_W-1:0] w_px, w_py, w_pz;
    logic [SQ_W-2:0] r_sx, r_sy, r_sz;
    logic [SQ_W-1:0] r_sum;
    t_tag r_tag1, r_tag2;

    assign w_px = (2*RAW_W)'(i_raw_x) * (2*RAW_W)'(i_raw_x);
    assign w_py = (2*RAW_W)'(i_raw_y) * (2*RAW_W)'(i_raw_y);
    assign w_pz = (2*RAW_W)'(i_raw_z) * (2*RAW_W)'(i_raw_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1.vld <= 1'b0;
            r_tag2.vld <= 1'b0;
        end else if (i_en) begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sx  <= w_px[SQ_W-2:0];
            r_sy  <= w_py[SQ_W-2:0];
            r_sz  <= w_pz[SQ_W-2:0];
            r_sum <= SQ_W'(r_sx) + SQ_W'(r_sy) + SQ_W'(r_sz);
        end
    end

    assign o_tag = r_tag2;
    assign o_sum = r_sum;

endmodule

[hw/rtl/ivm_sqrt.sv]
// Pipelined restoring square root of (sum << 2*FRAC_BITS), one root bit
// per stage. Depends on ivm_pkg.
module ivm_sqrt #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  ivm_pkg::t_tag                          i_tag,
    input  logic [ivm_pkg::SQ_W-1:0]               i_sum,
    output ivm_pkg::t_tag                          o_tag,
    output logic [ivm_pkg::RAW_W+FRAC_BITS-1:0]    o_root
);
    import ivm_pkg::*;

    localparam int R = RAW_W + FRAC_BITS;

    logic [R:0]      r_rem  [R];
    logic [R-1:0]    r_root [R];
    logic [SQ_W-1:0] r_src  [R];
    t_tag            r_tag  [R];

    for (genvar k = 0; k < R; k++) begin : g_stage
        logic [R:0]      p_rem;
        logic [R-1:0]    p_root;
        logic [SQ_W-1:0] p_src;
        t_tag            p_tag;
        logic [R+2:0]    trial, test, diff;
        logic            ge;

        if (k == 0) begin : g_first
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_src  = i_sum;
            assign p_tag  = i_tag;
        end else begin : g_next
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_src  = r_src[k-1];
            assign p_tag  = r_tag[k-1];
        end

        assign trial = {p_rem, p_src[SQ_W-1 -: 2]};
        assign test  = {1'b0, p_root, 2'b01};
        assign ge    = (trial >= test);
        assign diff  = trial - test;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[k].vld <= 1'b0;
            end else if (i_en) begin
                r_tag[k] <= p_tag;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? diff[R:0] : trial[R:0];
                r_root[k] <= {p_root[R-2:0], ge};
                r_src[k]  <= p_src << 2;
            end
        end
    end

    assign o_tag  = r_tag[R-1];
    assign o_root = r_root[R-1];

endmodule

[hw/rtl/ivm_cdiv.sv]
// Scales the root by ten and divides by the selected sensitivity in tenths,
// one quotient bit per stage, then saturates into the output register.
// Depends on ivm_pkg.
module ivm_cdiv #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  ivm_pkg::t_tag                          i_tag,
    input  logic [ivm_pkg::RAW_W+FRAC_BITS-1:0]    i_root,
    output logic                                   o_vld,
    output logic [ivm_pkg::MAG_W-1:0]              o_mag
);
    import ivm_pkg::*;

    localparam int R  = RAW_W + FRAC_BITS;
    localparam int NW = R + 4;

    logic [NW-1:0]    r_n0;
    t_tag             r_tag0;
    logic [NW-1:0]    r_nq  [NW];
    logic [DIV_W-1:0] r_rem [NW];
    t_tag             r_tag [NW];
    logic [NW-1:0]    w_quo;
    logic [MAG_W-1:0] w_mag;
    logic [MAG_W-1:0] r_mag;
    logic             r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag0.vld <= 1'b0;
        end else if (i_en) begin
            r_tag0 <= i_tag;
        end
    end

    // root * 10 = root * 8 + root * 2
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n0 <= NW'({i_root, 3'b000}) + NW'({i_root, 1'b0});
        end
    end

    // dividend bits shift out at the top while quotient bits shift in below
    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [NW-1:0]    p_nq;
        logic [DIV_W-1:0] p_rem;
        t_tag             p_tag;
        logic [DIV_W:0]   trial, diff;
        logic             ge;

        if (k == 0) begin : g_first
            assign p_nq  = r_n0;
            assign p_rem = '0;
            assign p_tag = r_tag0;
        end else begin : g_next
            assign p_nq  = r_nq[k-1];
            assign p_rem = r_rem[k-1];
            assign p_tag = r_tag[k-1];
        end

        assign trial = {p_rem, p_nq[NW-1]};
        assign ge    = (trial >= {1'b0, p_tag.div});
        assign diff  = trial - {1'b0, p_tag.div};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[k].vld <= 1'b0;
            end else if (i_en) begin
                r_tag[k] <= p_tag;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_nq[k]  <= {p_nq[NW-2:0], ge};
                r_rem[k] <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            end
        end
    end

    assign w_quo = r_nq[NW-1];

    if (NW > MAG_W) begin : g_sat
        assign w_mag = (|w_quo[NW-1:MAG_W]) ? '1 : w_quo[MAG_W-1:0];
    end else begin : g_nosat
        assign w_mag = MAG_W'(w_quo);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= r_tag[NW-1].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag <= w_mag;
        end
    end

    assign o_vld = r_vld;
    assign o_mag = r_mag;

endmodule

[hw/rtl/imu_vector_magnitude.sv]
// Channel   Direction  Handshake                    Payload
// in        input      i_in_valid / o_in_ready      i_req_type, i_raw_x, i_raw_y, i_raw_z
// out       output     o_out_valid / i_out_ready    o_magnitude
// cfg       input      i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// One sample per cycle while the output is not stalled; each sample passes the
// sum-of-squares stages, the one-bit-per-stage square root and constant divider.
// Synchronous active-low reset clears all valid bits and both range registers.
// A result held at the output freezes the whole pipeline; nothing moves or drops.
// Config writes are taken every cycle.
// Top level; depends on ivm_pkg, ivm_sqsum, ivm_sqrt, ivm_cdiv, assert_macros.svh.
`include "assert_macros.svh"

module imu_vector_magnitude #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_req_type,
    input  logic signed [ivm_pkg::RAW_W-1:0]   i_raw_x,
    input  logic signed [ivm_pkg::RAW_W-1:0]   i_raw_y,
    input  logic signed [ivm_pkg::RAW_W-1:0]   i_raw_z,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic        [ivm_pkg::MAG_W-1:0]   o_magnitude,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic                               i_cfg_index,
    input  logic        [ivm_pkg::RNG_W-1:0]   i_cfg_data
);
    import ivm_pkg::*;

    localparam int ROOT_W = RAW_W + FRAC_BITS;

    logic [RNG_W-1:0] r_gyro_rng, r_accel_rng;
    logic             w_en, w_in_fire, w_cfg_fire;
    t_tag             w_tag_in, w_tag_sum, w_tag_root;
    logic [SQ_W-1:0]  w_sum;
    logic [ROOT_W-1:0] w_root;

    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;
    assign w_in_fire  = i_in_valid && w_en;
    assign o_cfg_ready = 1'b1;
    assign w_cfg_fire  = i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gyro_rng  <= '0;
            r_accel_rng <= '0;
        end else if (w_cfg_fire) begin
            case (i_cfg_index)
                CFG_GYRO:  r_gyro_rng  <= i_cfg_data;
                CFG_ACCEL: r_accel_rng <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_tag_in.vld = w_in_fire;
    assign w_tag_in.div = divisor_tenths(i_req_type, r_gyro_rng, r_accel_rng);

    ivm_sqsum u_sqsum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_tag   (w_tag_in),
        .i_raw_x (i_raw_x),
        .i_raw_y (i_raw_y),
        .i_raw_z (i_raw_z),
        .o_tag   (w_tag_sum),
        .o_sum   (w_sum)
    );

    ivm_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_tag   (w_tag_sum),
        .i_sum   (w_sum),
        .o_tag   (w_tag_root),
        .o_root  (w_root)
    );

    ivm_cdiv #(.FRAC_BITS(FRAC_BITS)) u_cdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_tag   (w_tag_root),
        .i_root  (w_root),
        .o_vld   (o_out_valid),
        .o_mag   (o_magnitude)
    );

    `ASSERT_PROP(a_stall_blocks_input, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |-> !o_in_ready)
    `ASSERT_PROP(a_reset_empties_output, i_clk, i_rst_n, !$past(i_rst_n) |-> !o_out_valid)
    `ASSERT_PROP(a_gyro_only_on_write, i_clk, i_rst_n, ($past(i_rst_n) && (r_gyro_rng != $past(r_gyro_rng))) |-> ($past(w_cfg_fire) && ($past(i_cfg_index) == CFG_GYRO)))
    `ASSERT_PROP(a_accel_only_on_write, i_clk, i_rst_n, ($past(i_rst_n) && (r_accel_rng != $past(r_accel_rng))) |-> ($past(w_cfg_fire) && ($past(i_cfg_index) == CFG_ACCEL)))

endmodule

[tb/tb_imu_vector_magnitude.sv]
`timescale 1ns / 1ps
// Testbench for imu_vector_magnitude: directed and random three-axis samples under
// several range settings, checked by a scoreboard with a bit-exact magnitude predictor.
// Depends on ivm_pkg and the imu_vector_magnitude RTL.
module tb_imu_vector_magnitude;
    import ivm_pkg::*;

    localparam int LATENCY          = 72;
    localparam int MAX_WAIT         = 17;
    localparam int RANDOM_PER_PHASE = 150;
    localparam int N_PHASES         = 7;
    localparam int DRAIN_LIMIT      = 20000;
    localparam logic [MAG_W-1:0] MAG_SAT = '1;
    localparam int unsigned GYRO_DIV10  [4] = '{1310, 655, 328, 164};
    localparam int unsigned ACCEL_DIV10 [4] = '{163840, 81920, 40960, 20480};

    class mag_checker;
        logic [RNG_W-1:0] gyro_rng;
        logic [RNG_W-1:0] accel_rng;
        logic [MAG_W-1:0] expected_mag [$];
        int errors;
        int n_accel;
        int n_gyro;
        int n_checked;

        function new();
            gyro_rng  = '0;
            accel_rng = '0;
            errors    = 0;
            n_accel   = 0;
            n_gyro    = 0;
            n_checked = 0;
        endfunction

        // floor(isqrt(S << 32) * 10 / tenths), S = x^2 + y^2 + z^2, saturating at MAG_SAT
        function logic [MAG_W-1:0] predict_mag(
            logic rq,
            logic signed [RAW_W-1:0] x,
            logic signed [RAW_W-1:0] y,
            logic signed [RAW_W-1:0] z
        );
            logic [RAW_W:0]   ax;
            logic [RAW_W:0]   ay;
            logic [RAW_W:0]   az;
            logic [33:0]      sum_sq;
            logic [65:0]      scaled;
            logic [33:0]      root;
            logic [33:0]      trial;
            logic [67:0]      trial_sq;
            logic [39:0]      quot;
            int unsigned      div10;
            ax = x[RAW_W-1] ? 17'h10000 - {1'b0, x} : {1'b0, x};
            ay = y[RAW_W-1] ? 17'h10000 - {1'b0, y} : {1'b0, y};
            az = z[RAW_W-1] ? 17'h10000 - {1'b0, z} : {1'b0, z};
            sum_sq = 34'(ax) * 34'(ax) + 34'(ay) * 34'(ay) + 34'(az) * 34'(az);
            scaled = {sum_sq, 32'd0};
            root = '0;
            for (int b = 33; b >= 0; b--) begin
                trial    = root | (34'd1 << b);
                trial_sq = {34'd0, trial} * {34'd0, trial};
                if (trial_sq <= {2'b00, scaled}) begin
                    root = trial;
                end
            end
            div10 = (rq == REQ_GYRO) ? GYRO_DIV10[gyro_rng] : ACCEL_DIV10[accel_rng];
            quot  = ({6'd0, root} * 40'd10) / 40'(div10);
            if (quot > 40'(MAG_SAT)) begin
                quot = 40'(MAG_SAT);
            end
            return quot[MAG_W-1:0];
        endfunction

        function void note_sample(
            logic rq,
            logic signed [RAW_W-1:0] x,
            logic signed [RAW_W-1:0] y,
            logic signed [RAW_W-1:0] z
        );
            expected_mag.push_back(predict_mag(rq, x, y, z));
            if (rq == REQ_GYRO) begin
                n_gyro++;
            end else begin
                n_accel++;
            end
        endfunction

        function void check_magnitude(logic [MAG_W-1:0] actual);
            logic [MAG_W-1:0] want;
            if (expected_mag.size() == 0) begin
                $error("unexpected result transfer: magnitude %0d", actual);
                errors++;
                return;
            end
            want = expected_mag.pop_front();
            n_checked++;
            if (want !== actual) begin
                $error("magnitude mismatch: expected %0d, actual %0d", want, actual);
                errors++;
            end
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     in_valid;
    logic                     o_in_ready;
    logic                     req_type;
    logic signed [RAW_W-1:0]  raw_x;
    logic signed [RAW_W-1:0]  raw_y;
    logic signed [RAW_W-1:0]  raw_z;
    logic                     o_out_valid;
    logic                     out_ready;
    logic [MAG_W-1:0]         o_magnitude;
    logic                     cfg_valid;
    logic                     o_cfg_ready;
    logic                     cfg_index;
    logic [RNG_W-1:0]         cfg_data;

    mag_checker sb;
    bit         in_burst;
    int         n_settings;

    imu_vector_magnitude uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (req_type),
        .i_raw_x     (raw_x),
        .i_raw_y     (raw_y),
        .i_raw_z     (raw_z),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_magnitude (o_magnitude),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && in_valid && o_in_ready) begin
            sb.note_sample(req_type, raw_x, raw_y, raw_z);
        end
        if (i_rst_n && o_out_valid && out_ready) begin
            sb.check_magnitude(o_magnitude);
        end
    end

    task automatic send_sample(
        input logic rq,
        input logic signed [RAW_W-1:0] x,
        input logic signed [RAW_W-1:0] y,
        input logic signed [RAW_W-1:0] z
    );
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            @(negedge i_clk) in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_valid <= 1'b1;
        req_type <= rq;
        raw_x    <= x;
        raw_y    <= y;
        raw_z    <= z;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic wait_drained();
        while (sb.expected_mag.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic idx, input logic [RNG_W-1:0] value);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_GYRO) begin
            sb.gyro_rng = value;
        end else begin
            sb.accel_rng = value;
        end
        @(negedge i_clk) cfg_valid <= 1'b0;
    endtask

    task automatic set_ranges(input logic [RNG_W-1:0] g, input logic [RNG_W-1:0] a);
        @(negedge i_clk) in_valid <= 1'b0;
        wait_drained();
        write_reg(CFG_GYRO, g);
        write_reg(CFG_ACCEL, a);
        n_settings++;
    endtask

    function automatic logic signed [RAW_W-1:0] pick_axis();
        logic signed [RAW_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = 16'sh8000;
            1: v = 16'sh7FFF;
            2: v = '0;
            3, 4: begin
                v = RAW_W'($urandom_range(0, 100));
                if ($urandom_range(0, 1) == 1) begin
                    v = -v;
                end
            end
            default: v = RAW_W'($urandom());
        endcase
        return v;
    endfunction

    // receiver: random stalls per result, with stretches of none
    initial begin
        int stall;
        int k;
        bit out_burst;
        out_ready = 1'b0;
        out_burst = 1'b0;
        k = 0;
        @(posedge i_rst_n);
        forever begin
            if (k % 40 == 0) begin
                out_burst = ($urandom_range(0, 3) == 0);
            end
            k++;
            stall = out_burst ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0) begin
                @(negedge i_clk) out_ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk) out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && out_ready));
        end
    end

    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        logic             rq;
        logic [RNG_W-1:0] g;
        logic [RNG_W-1:0] a;
        int               guard;
        sb         = new();
        n_settings = 1;
        in_burst   = 1'b0;
        i_rst_n    = 1'b0;
        in_valid   = 1'b0;
        req_type   = REQ_ACCEL;
        raw_x      = '0;
        raw_y      = '0;
        raw_z      = '0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_GYRO;
        cfg_data   = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // directed: zero, full-scale corners, single axes, sign patterns
        for (int r = 0; r < 2; r++) begin
            rq = (r == 0) ? REQ_ACCEL : REQ_GYRO;
            send_sample(rq, 16'sh0000, 16'sh0000, 16'sh0000);
            send_sample(rq, 16'sh8000, 16'sh8000, 16'sh8000);
            send_sample(rq, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
            send_sample(rq, 16'sh8000, 16'sh0000, 16'sh0000);
            send_sample(rq, 16'sh0000, 16'sh7FFF, 16'sh0000);
            send_sample(rq, 16'sh0000, 16'sh0000, 16'sh8000);
            send_sample(rq, 16'sh0001, 16'sh0000, 16'sh0000);
            send_sample(rq, 16'shFFFF, 16'shFFFF, 16'shFFFF);
            send_sample(rq, 16'sh8000, 16'sh7FFF, 16'sh0001);
            send_sample(rq, 16'sh5555, 16'shAAAA, 16'sh00FF);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            if (p > 0) begin
                case (p)
                    1: begin g = 2'd3; a = 2'd3; end
                    2: begin g = 2'd1; a = 2'd2; end
                    3: begin g = 2'd2; a = 2'd1; end
                    4: begin g = 2'd0; a = 2'd3; end
                    5: begin g = 2'd3; a = 2'd0; end
                    default: begin g = RNG_W'($urandom()); a = RNG_W'($urandom()); end
                endcase
                set_ranges(g, a);
            end
            for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
                if (k % 40 == 0) begin
                    in_burst = ($urandom_range(0, 3) == 0);
                end
                if (p == 2 && k == RANDOM_PER_PHASE / 2) begin
                    @(negedge i_clk) in_valid <= 1'b0;
                    wait_drained();
                end
                rq = $urandom_range(0, 1) ? REQ_GYRO : REQ_ACCEL;
                send_sample(rq, pick_axis(), pick_axis(), pick_axis());
            end
        end

        @(negedge i_clk) in_valid <= 1'b0;
        guard = 0;
        while (sb.expected_mag.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (LATENCY + 8) @(posedge i_clk);
        if (sb.expected_mag.size() != 0) begin
            $error("%0d expected magnitudes never arrived", sb.expected_mag.size());
            sb.errors++;
        end

        $display("Checked %0d magnitudes from %0d accelerometer and %0d gyroscope samples",
                 sb.n_checked, sb.n_accel, sb.n_gyro);
        $display("Ran under %0d range settings, both extremes of each register included",
                 n_settings);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/ivm_pkg.sv
hw/rtl/ivm_sqsum.sv
hw/rtl/ivm_sqrt.sv
hw/rtl/ivm_cdiv.sv
hw/rtl/imu_vector_magnitude.sv
tb/tb_imu_vector_magnitude.sv
